FILE: hdl/imm_pkg.sv
// Shared types, sizes and helpers for the integer matrix multiply block.
package imm_pkg;

  localparam int MAX_DIM    = 8;
  localparam int DATA_WIDTH = 32;
  localparam int CFG_W      = 4;
  localparam int DIM_W      = $clog2(MAX_DIM + 1);
  localparam int IDX_W      = $clog2(MAX_DIM);
  localparam int ADDR_W     = $clog2(MAX_DIM * MAX_DIM);
  localparam int CNT_W      = 8;
  localparam int CMDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 2;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  typedef logic [CFG_W-1:0]      cfg_val_t;
  typedef logic [DIM_W-1:0]      dim_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2
  } reg_idx_t;

  // Configuration as seen by the front end
  typedef struct packed {
    cfg_val_t rows_a;
    cfg_val_t inner_dim;
    cfg_val_t cols_b;
  } cfg_t;

  // One classified item on its way to the back end
  typedef struct packed {
    logic  we;      // store the element
    logic  sel_b;   // element belongs to B
    addr_t addr;
    data_t data;
    logic  done;    // element completes B: run the product
    dim_t  m;
    dim_t  k;
    dim_t  n;
  } cmd_t;

  // One result element
  typedef struct packed {
    data_t value;
    idx_t  row;
    idx_t  col;
    logic  last;
  } result_t;

  // Clamp a register value into 1..MAX_DIM
  function automatic dim_t eff_dim(input cfg_val_t v);
    dim_t r;
    if (v == '0) begin
      r = dim_t'(1);
    end else if ({1'b0, v} > (CFG_W+1)'(MAX_DIM)) begin
      r = dim_t'(MAX_DIM);
    end else begin
      r = dim_t'(v);
    end
    return r;
  endfunction

endpackage

FILE: hdl/imm_front.sv
// Front end: counts loaded elements and classifies each item into a store command.
module imm_front (
  input  logic            clk,
  input  logic            rst,
  input  imm_pkg::cfg_t   cfg,
  input  logic            push,
  input  imm_pkg::data_t  element,
  output logic            full,
  output logic            cmd_push,
  output imm_pkg::cmd_t   cmd,
  input  logic            cmd_full
);

  imm_pkg::dim_t m;
  imm_pkg::dim_t k;
  imm_pkg::dim_t n;
  imm_pkg::cnt_t size_a;
  imm_pkg::cnt_t total;
  imm_pkg::cnt_t off;
  imm_pkg::cnt_t load_count;
  imm_pkg::cnt_t load_count_next;
  logic          is_a;
  logic          done;

  // Effective dimensions, evaluated for every item
  assign m = imm_pkg::eff_dim(cfg.rows_a);
  assign k = imm_pkg::eff_dim(cfg.inner_dim);
  assign n = imm_pkg::eff_dim(cfg.cols_b);

  assign size_a = imm_pkg::cnt_t'(m) * imm_pkg::cnt_t'(k);
  assign total  = size_a + imm_pkg::cnt_t'(k) * imm_pkg::cnt_t'(n);

  // Classify: A or B, store offset, completion
  assign is_a = load_count < size_a;
  assign off  = load_count - size_a;
  assign done = !({1'b0, load_count} + 9'd1 < {1'b0, total});

  assign load_count_next = done ? '0 : load_count + imm_pkg::cnt_t'(1);

  assign full     = cmd_full;
  assign cmd_push = push && !cmd_full;

  always_comb begin
    cmd.we    = is_a || (off < imm_pkg::cnt_t'(imm_pkg::MAX_DIM * imm_pkg::MAX_DIM));
    cmd.sel_b = !is_a;
    cmd.addr  = is_a ? load_count[imm_pkg::ADDR_W-1:0] : off[imm_pkg::ADDR_W-1:0];
    cmd.data  = element;
    cmd.done  = done;
    cmd.m     = m;
    cmd.k     = k;
    cmd.n     = n;
  end

  // Advance the load count on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (cmd_push) begin
      load_count <= load_count_next;
    end
  end

endmodule

FILE: hdl/imm_cmdq.sv
// Command queue between the front end and the compute back end.
module imm_cmdq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  imm_pkg::cmd_t wr,
  output logic          full,
  input  logic          pop,
  output imm_pkg::cmd_t rd,
  output logic          empty
);

  localparam int PtrW = $clog2(imm_pkg::CMDQ_DEPTH);

  imm_pkg::cmd_t   q [imm_pkg::CMDQ_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;

  assign full  = count == (PtrW+1)'(imm_pkg::CMDQ_DEPTH);
  assign empty = count == '0;
  assign rd    = q[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push && !full) begin
      q[wr_ptr] <= wr;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + (PtrW+1)'(1);
        2'b01:   count <= count - (PtrW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/imm_back.sv
// Back end: matrix stores, multiply-accumulate pipeline and result queue.
module imm_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_empty,
  input  imm_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output logic             busy,
  input  logic             pop,
  output logic             empty,
  output imm_pkg::result_t res
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  localparam int Depth = imm_pkg::MAX_DIM * imm_pkg::MAX_DIM;
  localparam int OutW  = $clog2(imm_pkg::OUTQ_DEPTH);

  state_t         state;
  imm_pkg::data_t store_a [Depth];
  imm_pkg::data_t store_b [Depth];
  imm_pkg::dim_t  m;
  imm_pkg::dim_t  k;
  imm_pkg::dim_t  n;
  imm_pkg::idx_t  i;
  imm_pkg::idx_t  j;
  imm_pkg::idx_t  t;
  logic           i_last;
  logic           j_last;
  logic           t_last;
  imm_pkg::addr_t a_addr;
  imm_pkg::addr_t b_addr;
  imm_pkg::data_t ra;
  imm_pkg::data_t rb;
  imm_pkg::data_t prod;
  imm_pkg::data_t acc;
  logic           v1;
  logic           l1;
  logic           v2;
  logic           l2;
  logic           issue;

  imm_pkg::result_t outq [imm_pkg::OUTQ_DEPTH];
  logic [OutW-1:0]  out_wr;
  logic [OutW-1:0]  out_rd;
  logic [OutW:0]    out_count;
  logic             out_push;
  logic             out_pop;

  assign busy    = state != S_IDLE;
  assign cmd_pop = (state == S_IDLE) && !cmd_empty;
  assign issue   = state == S_ISSUE;

  assign i_last = (imm_pkg::dim_t'(i) + imm_pkg::dim_t'(1)) == m;
  assign j_last = (imm_pkg::dim_t'(j) + imm_pkg::dim_t'(1)) == n;
  assign t_last = (imm_pkg::dim_t'(t) + imm_pkg::dim_t'(1)) == k;

  // A is read along row i, B down column j
  assign a_addr = imm_pkg::addr_t'(i) * imm_pkg::addr_t'(k) + imm_pkg::addr_t'(t);
  assign b_addr = imm_pkg::addr_t'(t) * imm_pkg::addr_t'(n) + imm_pkg::addr_t'(j);

  // Write the stores from popped commands
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.we) begin
      if (cmd.sel_b) begin
        store_b[cmd.addr] <= cmd.data;
      end else begin
        store_a[cmd.addr] <= cmd.data;
      end
    end
  end

  // Read both stores for one term of the dot product
  always_ff @(posedge clk) begin
    if (issue) begin
      ra <= store_a[a_addr];
      rb <= store_b[b_addr];
    end
  end

  // Multiply the operands read last cycle
  always_ff @(posedge clk) begin
    prod <= ra * rb;
  end

  // Track term valid and end-of-dot-product tags down the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      l1 <= 1'b0;
      v2 <= 1'b0;
      l2 <= 1'b0;
    end else begin
      v1 <= issue;
      l1 <= issue && t_last;
      v2 <= v1;
      l2 <= l1;
    end
  end

  assign out_push = (state == S_EMIT) && (out_count != (OutW+1)'(imm_pkg::OUTQ_DEPTH));
  assign out_pop  = pop && !empty;

  // Sequence the product: issue terms, drain, emit one result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_pop && cmd.done) begin
            m     <= cmd.m;
            k     <= cmd.k;
            n     <= cmd.n;
            i     <= '0;
            j     <= '0;
            t     <= '0;
            acc   <= '0;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (t_last) begin
            t     <= '0;
            state <= S_DRAIN;
          end else begin
            t <= t + imm_pkg::idx_t'(1);
          end
          if (v2) begin
            acc <= acc + prod;
          end
        end
        S_DRAIN: begin
          if (v2) begin
            acc <= acc + prod;
          end
          if (v2 && l2) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_push) begin
            acc <= '0;
            if (j_last) begin
              j <= '0;
              if (i_last) begin
                state <= S_IDLE;
              end else begin
                i     <= i + imm_pkg::idx_t'(1);
                state <= S_ISSUE;
              end
            end else begin
              j     <= j + imm_pkg::idx_t'(1);
              state <= S_ISSUE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Hold finished results until taken
  always_ff @(posedge clk) begin
    if (out_push) begin
      outq[out_wr] <= '{value: acc, row: i, col: j, last: i_last && j_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr    <= '0;
      out_rd    <= '0;
      out_count <= '0;
    end else begin
      if (out_push) begin
        out_wr <= out_wr + OutW'(1);
      end
      if (out_pop) begin
        out_rd <= out_rd + OutW'(1);
      end
      case ({out_push, out_pop})
        2'b10:   out_count <= out_count + (OutW+1)'(1);
        2'b01:   out_count <= out_count - (OutW+1)'(1);
        default: out_count <= out_count;
      endcase
    end
  end

  assign empty = out_count == '0;
  assign res   = outq[out_rd];

endmodule

FILE: hdl/integer_matrix_multiply_top.sv
// Top level of the integer matrix multiply block: configuration registers and wiring.
//
//   channel   direction  handshake            payload
//   config    in/out     psel/penable/pready  paddr, pwdata, prdata
//   element   in         push / full          element
//   result    out        pop / empty          product_value, out_row, out_col, last_of_matrix
//
// Each load item is taken in the cycle it is pushed; full rises only when the four-entry
// command queue backs up behind a running product.
// The item that completes B starts rows_a * cols_b results, each passing through
// the shared multiply-accumulate pipeline (one store read per term, one multiply,
// one accumulate, one emit).
// A two-entry result queue lets the pipeline run ahead of pop.
// rst is synchronous; it clears the load count and queues and sets each dimension to 8.
module integer_matrix_multiply_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [imm_pkg::APB_AW-1:0]          paddr,
  input  logic [imm_pkg::APB_DW-1:0]          pwdata,
  output logic [imm_pkg::APB_DW-1:0]          prdata,
  output logic                                pready,
  input  logic                                push,
  input  logic signed [imm_pkg::DATA_WIDTH-1:0] element,
  output logic                                full,
  input  logic                                pop,
  output logic                                empty,
  output logic signed [imm_pkg::DATA_WIDTH-1:0] product_value,
  output logic [imm_pkg::IDX_W-1:0]           out_row,
  output logic [imm_pkg::IDX_W-1:0]           out_col,
  output logic                                last_of_matrix
);

  imm_pkg::cfg_t     cfg;
  imm_pkg::reg_idx_t reg_idx;
  logic              cfg_wr;
  logic              cmd_push;
  logic              cmd_pop;
  logic              cmd_full;
  logic              cmd_empty;
  imm_pkg::cmd_t     cmd_wr;
  imm_pkg::cmd_t     cmd_rd;
  logic              back_busy;
  imm_pkg::result_t  res;

  assign pready  = 1'b1;
  assign reg_idx = imm_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Write the dimension registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows_a    <= imm_pkg::cfg_val_t'(imm_pkg::MAX_DIM);
      cfg.inner_dim <= imm_pkg::cfg_val_t'(imm_pkg::MAX_DIM);
      cfg.cols_b    <= imm_pkg::cfg_val_t'(imm_pkg::MAX_DIM);
    end else if (cfg_wr) begin
      case (reg_idx)
        imm_pkg::REG_ROWS_A:    cfg.rows_a    <= pwdata[imm_pkg::CFG_W-1:0];
        imm_pkg::REG_INNER_DIM: cfg.inner_dim <= pwdata[imm_pkg::CFG_W-1:0];
        imm_pkg::REG_COLS_B:    cfg.cols_b    <= pwdata[imm_pkg::CFG_W-1:0];
        default:                cfg           <= cfg;
      endcase
    end
  end

  // Read back the dimension registers
  always_comb begin
    case (reg_idx)
      imm_pkg::REG_ROWS_A:    prdata = imm_pkg::APB_DW'(cfg.rows_a);
      imm_pkg::REG_INNER_DIM: prdata = imm_pkg::APB_DW'(cfg.inner_dim);
      imm_pkg::REG_COLS_B:    prdata = imm_pkg::APB_DW'(cfg.cols_b);
      default:                prdata = '0;
    endcase
  end

  imm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .element  (element),
    .full     (full),
    .cmd_push (cmd_push),
    .cmd      (cmd_wr),
    .cmd_full (cmd_full)
  );

  imm_cmdq u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wr    (cmd_wr),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rd    (cmd_rd),
    .empty (cmd_empty)
  );

  imm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_rd),
    .cmd_pop   (cmd_pop),
    .busy      (back_busy),
    .pop       (pop),
    .empty     (empty),
    .res       (res)
  );

  assign product_value  = res.value;
  assign out_row        = res.row;
  assign out_col        = res.col;
  assign last_of_matrix = res.last;

  // Reset leaves no result waiting and room for items
  a_reset_clean: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not clear after reset");

  // The back end takes commands only when some are queued
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from empty queue");

  // A completing command starts the product
  a_done_starts: assert property (@(posedge clk) disable iff (rst)
    cmd_pop && cmd_rd.done |=> back_busy)
    else $error("product did not start after completing item");

endmodule
